// ----- rtl/core/hfc_pkg.sv -----
// Shared types and constants for the half/single precision converter.
// No dependencies; imported by every module of the converter.
`default_nettype none

package hfc_pkg;

	// Direction select carried with each item.
	typedef enum logic {
		CMD_S2H = 1'b0,
		CMD_H2S = 1'b1
	} cmd_t;

	// Difference between the single bias (127) and the half bias (15).
	localparam logic [7:0] EXP_DIFF = 8'd112;
	// Single exponents below this are too small for any half subnormal.
	localparam logic [7:0] TINY_EXP = 8'd102;
	// Single exponents at or above this overflow the half range.
	localparam logic [7:0] OVF_EXP = 8'd143;
	// All-ones exponent fields mark infinity and NaN.
	localparam logic [7:0] SGL_EXP_SPECIAL = 8'hff;
	localparam logic [4:0] HLF_EXP_SPECIAL = 5'h1f;
	// Half magnitude patterns for infinity and the canonical quiet NaN.
	localparam logic [14:0] HALF_INF = 15'h7c00;
	localparam logic [14:0] HALF_QNAN = 15'h7e00;

endpackage

`default_nettype wire

// ----- rtl/core/hfc_s2h.sv -----
// Single to half conversion logic, purely combinational.
// Depends on hfc_pkg for exponent limits and special patterns.
`default_nettype none

module hfc_s2h
	import hfc_pkg::*;
(
	input  wire logic [31:0] single_in,
	output logic      [15:0] half_out
);

	logic        sign;
	logic [7:0]  ebits;
	logic [22:0] mant;
	logic [3:0]  sub_shift;
	logic [23:0] sub_shifted;
	logic [10:0] sub_round;
	logic [4:0]  norm_exp;
	logic [14:0] norm_round;

	assign sign  = single_in[31];
	assign ebits = single_in[30:23];
	assign mant  = single_in[22:0];

	// Subnormal path: shift in the hidden bit, then round at the guard bit.
	assign sub_shift   = 4'(8'd113 - ebits);
	assign sub_shifted = {1'b1, mant} >> sub_shift;
	assign sub_round   = sub_shifted[23:13] + {10'd0, sub_shifted[12]};

	// Normal path: the rounding carry ripples from the mantissa into the
	// exponent, and a carry into exponent 31 yields the infinity pattern.
	assign norm_exp   = 5'(ebits - EXP_DIFF);
	assign norm_round = {norm_exp, mant[22:13]} + {14'd0, mant[12]};

	// Select the result by exponent range.
	always_comb begin
		if (ebits == SGL_EXP_SPECIAL) begin
			half_out = {sign, (mant == 23'd0) ? HALF_INF : HALF_QNAN};
		end else if (ebits < TINY_EXP) begin
			half_out = {sign, 15'd0};
		end else if (ebits <= EXP_DIFF) begin
			half_out = {sign, 4'd0, sub_round};
		end else if (ebits >= OVF_EXP) begin
			half_out = {sign, HALF_INF};
		end else begin
			half_out = {sign, norm_round};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/hfc_h2s.sv -----
// Half to single conversion logic, purely combinational.
// Depends on hfc_pkg for exponent constants.
`default_nettype none

module hfc_h2s
	import hfc_pkg::*;
(
	input  wire logic [15:0] half_in,
	output logic      [31:0] single_out
);

	logic        sign;
	logic [4:0]  ebits;
	logic [9:0]  mant;
	logic [3:0]  lead_zeros;
	logic [3:0]  norm_shift;
	logic [7:0]  sub_exp;
	logic [9:0]  sub_mant;

	assign sign  = half_in[15];
	assign ebits = half_in[14:10];
	assign mant  = half_in[9:0];

	// Leading-zero count of the subnormal mantissa; the highest set bit wins.
	always_comb begin
		lead_zeros = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (mant[i]) begin
				lead_zeros = 4'(9 - i);
			end
		end
	end

	// Normalize: shift the leading one out past the hidden bit position.
	assign norm_shift = lead_zeros + 4'd1;
	assign sub_exp    = 8'd113 - {4'd0, norm_shift};
	assign sub_mant   = 10'(mant << norm_shift);

	// Select the result by exponent class.
	always_comb begin
		if (ebits == 5'd0) begin
			if (mant == 10'd0) begin
				single_out = {sign, 31'd0};
			end else begin
				single_out = {sign, sub_exp, sub_mant, 13'd0};
			end
		end else if (ebits == HLF_EXP_SPECIAL) begin
			single_out = {sign, SGL_EXP_SPECIAL, mant, 13'd0};
		end else begin
			single_out = {sign, {3'd0, ebits} + EXP_DIFF, mant, 13'd0};
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/half_float_converter.sv -----
// Half/single converter top level: an item moves from the input register to the
// result register, which loads it once the result stage is empty or moves on.
// Throughput is one item per cycle while out_stall does not hold a full result stage;
// the conversion is a single short logic stage between the input register and
// the result register.
// Reset (arst_n, asynchronous, active low) clears both stage valid flags;
// payload registers are not reset.
`default_nettype none

module half_float_converter
	import hfc_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [31:0] single_in,
	input  wire logic [15:0] half_in,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic      [15:0] half_out,
	output logic      [31:0] single_out
);

	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [31:0] single_s1;
	logic [15:0] half_s1;
	logic        valid_s2;
	logic [15:0] half_s2;
	logic [31:0] single_s2;
	logic        adv_s2;
	logic        adv_s1;
	logic [15:0] s2h_result;
	logic [31:0] h2s_result;

	// Stage advance: a stage loads when it is empty or its content moves on.
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			cmd_s1    <= cmd_t'(command);
			single_s1 <= single_in;
			half_s1   <= half_in;
		end
	end

	// Conversion logic for both directions.
	hfc_s2h u_s2h (
		.single_in (single_s1),
		.half_out  (s2h_result)
	);

	hfc_h2s u_h2s (
		.half_in    (half_s1),
		.single_out (h2s_result)
	);

	// Result register; the unselected direction reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			half_s2   <= (cmd_s1 == CMD_S2H) ? s2h_result : 16'd0;
			single_s2 <= (cmd_s1 == CMD_H2S) ? h2s_result : 32'd0;
		end
	end

	assign out_valid  = valid_s2;
	assign half_out   = half_s2;
	assign single_out = single_s2;

`ifndef ASSERT_OFF
	// Back-pressure on the input only arises from a full, stalled result stage.
	a_stall_source: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && out_stall))
		else $error("input stalled without a stalled full pipeline");

	// A held item in the input register is not dropped while stalled.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> valid_s1)
		else $error("stalled input stage lost its item");

	// Only one direction can produce a nonzero result.
	a_one_direction: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (half_out == 16'd0 || single_out == 32'd0))
		else $error("both result fields nonzero");
`endif

endmodule

`default_nettype wire
